### sv/spp_pkg.sv
// shared widths, codes and types for the simplex pivot selection block
// used by spp_divider and simplex_pivot_selection, no dependencies
package spp_pkg;

    localparam int IDX_W    = 12;                 // column or row index
    localparam int VAL_W    = 32;                 // signed Q16.16 operand
    localparam int FRAC_W   = 16;                 // fractional bits of Q16.16
    localparam int QUO_W    = VAL_W - 1;          // positive quotient magnitude
    localparam int SAT_SH   = QUO_W - FRAC_W;     // integer bits that fit unsaturated
    localparam int CNT_W    = $clog2(QUO_W);      // divider step counter
    localparam int MAX_DIM  = 4096;               // positions at or above are ignored
    localparam int S_DATA_W = 80;                 // position, value_a, value_b, padded
    localparam int M_DATA_W = 16;                 // found, chosen_index, padded

    // func / kind codes
    localparam logic FUNC_COL = 1'b0;
    localparam logic FUNC_ROW = 1'b1;

    // column rule codes
    localparam logic RULE_FIRST = 1'b0;
    localparam logic RULE_MAX   = 1'b1;

    typedef struct packed {
        logic busy;
        logic done;
    } spp_div_stat_t;

endpackage

### sv/spp_divider.sv
// radix-2 restoring divider for the positive Q16.16 ratio, one quotient bit a cycle
// saturates to the largest positive value; depends on spp_pkg
module spp_divider (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [spp_pkg::VAL_W-1:0]      dividend,   // magnitude, nonzero
    input  logic [spp_pkg::VAL_W-1:0]      divisor,    // magnitude, nonzero
    output spp_pkg::spp_div_stat_t         stat,
    output logic [spp_pkg::QUO_W-1:0]      quotient
);

    logic                        busy_reg;
    logic                        done_reg;
    logic [spp_pkg::CNT_W-1:0]   cnt_reg;
    logic [spp_pkg::VAL_W-1:0]   rem_reg;
    logic [spp_pkg::VAL_W-1:0]   dsr_reg;
    logic [spp_pkg::QUO_W-1:0]   dvd_reg;    // dividend bits shift out, quotient bits shift in

    logic                        sat;
    logic [spp_pkg::VAL_W:0]     trial;
    logic [spp_pkg::VAL_W:0]     diff;
    logic                        ge;

    // quotient reaches 2^QUO_W exactly when dividend >= divisor * 2^SAT_SH
    assign sat   = {{spp_pkg::SAT_SH{1'b0}}, dividend} >=
                   {divisor, {spp_pkg::SAT_SH{1'b0}}};
    assign trial = {rem_reg, dvd_reg[spp_pkg::QUO_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign ge    = trial >= {1'b0, dsr_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= !sat;
                done_reg <= sat;
            end else if (busy_reg && cnt_reg == '0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            cnt_reg <= spp_pkg::CNT_W'(spp_pkg::QUO_W - 1);
            dsr_reg <= divisor;
            // partial remainder starts with the integer bits above the quotient range
            rem_reg <= spp_pkg::VAL_W'(dividend >> spp_pkg::SAT_SH);
            if (sat) begin
                dvd_reg <= '1;
            end else begin
                dvd_reg <= {dividend[spp_pkg::SAT_SH-1:0], {spp_pkg::FRAC_W{1'b0}}};
            end
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            rem_reg <= ge ? diff[spp_pkg::VAL_W-1:0] : trial[spp_pkg::VAL_W-1:0];
            dvd_reg <= {dvd_reg[spp_pkg::QUO_W-2:0], ge};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = dvd_reg;

endmodule

### sv/simplex_pivot_selection.sv
// simplex pivot selection: column scan and ratio test over streamed tableau elements
// depends on spp_pkg and spp_divider
//
// usage: one tableau element per input beat on the s_axis channel. tuser is func
// (0 objective coefficient, 1 constraint row), tlast marks the end of a scan.
// on the beat with tlast the block sends one m_axis beat: tuser is the kind
// (func of that beat), tdata holds found and chosen_index.
// pivot_rule_we/pivot_rule_wdata set the column rule (0 first positive, 1 largest);
// write it only while no scan is in progress.
// an element is taken only in the idle state, so the block takes no new beat before
// it is through with the last one; an objective element or a row that needs no
// division goes through prepare and update, and a row that needs a division also
// waits in the divide state on the radix-2 divider, which retires one quotient bit
// per cycle; a saturating quotient is known at start. a beat with tlast then goes
// to the emit state, which hands its result to the output register once it is free.
// the output register holds a result while the receiver stalls; the block keeps
// taking elements meanwhile and only waits if a second result is ready before
// the first is taken. reset (aresetn low, synchronous) clears the running best,
// the column rule and the output valid.
module simplex_pivot_selection (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            pivot_rule_we,
    input  logic                            pivot_rule_wdata,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [spp_pkg::S_DATA_W-1:0]    s_axis_tdata,  // position, value_a, value_b, pad
    input  logic                            s_axis_tuser,  // func
    input  logic                            s_axis_tlast,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [spp_pkg::M_DATA_W-1:0]    m_axis_tdata,  // found, chosen_index, pad
    output logic                            m_axis_tuser   // kind
);

    localparam int IW = spp_pkg::IDX_W;
    localparam int VW = spp_pkg::VAL_W;
    localparam int QW = spp_pkg::QUO_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_UPD,
        ST_EMIT
    } state_t;

    state_t                 state_reg;
    logic                   rule_reg;
    logic                   func_reg;
    logic [IW-1:0]          pos_reg;
    logic [VW-1:0]          a_reg;
    logic [VW-1:0]          b_reg;
    logic                   last_reg;
    logic                   cand_valid_reg;
    logic [QW-1:0]          cand_val_reg;
    logic                   have_best_reg;
    logic [IW-1:0]          best_index_reg;
    logic [QW-1:0]          best_value_reg;
    logic                   out_valid_reg;
    logic                   out_kind_reg;
    logic                   out_found_reg;
    logic [IW-1:0]          out_index_reg;

    logic                   in_beat;
    logic                   pos_ok;
    logic                   a_zero;
    logic                   a_pos;
    logic                   b_zero;
    logic [VW-1:0]          a_mag;
    logic [VW-1:0]          b_mag;
    logic                   div_start;
    spp_pkg::spp_div_stat_t div_stat;
    logic [QW-1:0]          div_quo;
    logic                   better;
    logic                   out_free;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_beat       = s_axis_tvalid && s_axis_tready;

    assign pos_ok = (pos_reg != '0) && ({1'b0, pos_reg} < (IW + 1)'(spp_pkg::MAX_DIM));
    assign a_zero = (a_reg == '0);
    assign b_zero = (b_reg == '0);
    assign a_pos  = !a_reg[VW-1] && !a_zero;
    assign a_mag  = a_reg[VW-1] ? (~a_reg + 1'b1) : a_reg;
    assign b_mag  = b_reg[VW-1] ? (~b_reg + 1'b1) : b_reg;

    // division only for a same-sign row with in-range position, nonzero rhs and coefficient
    assign div_start = (state_reg == ST_PREP) && pos_ok && (func_reg == spp_pkg::FUNC_ROW)
                       && !b_zero && !a_zero && (a_reg[VW-1] == b_reg[VW-1]);

    spp_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (a_mag),
        .divisor  (b_mag),
        .stat     (div_stat),
        .quotient (div_quo)
    );

    always_comb begin
        better = 1'b0;
        if (cand_valid_reg) begin
            if (!have_best_reg) begin
                better = 1'b1;
            end else if (func_reg == spp_pkg::FUNC_ROW) begin
                better = cand_val_reg < best_value_reg;
            end else if (rule_reg == spp_pkg::RULE_MAX) begin
                better = cand_val_reg > best_value_reg;
            end
        end
    end

    assign out_free = !out_valid_reg || m_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            rule_reg       <= spp_pkg::RULE_FIRST;
            have_best_reg  <= 1'b0;
            best_index_reg <= '0;
            best_value_reg <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (pivot_rule_we) begin
                rule_reg <= pivot_rule_wdata;
            end
            if (state_reg == ST_EMIT && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (out_valid_reg && m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_beat) begin
                        func_reg  <= s_axis_tuser;
                        pos_reg   <= s_axis_tdata[IW-1:0];
                        a_reg     <= s_axis_tdata[IW+VW-1:IW];
                        b_reg     <= s_axis_tdata[IW+2*VW-1:IW+VW];
                        last_reg  <= s_axis_tlast;
                        state_reg <= ST_PREP;
                    end
                end
                ST_PREP: begin
                    cand_valid_reg <= 1'b0;
                    cand_val_reg   <= a_reg[QW-1:0];
                    if (div_start) begin
                        state_reg <= ST_DIV;
                    end else begin
                        if (pos_ok) begin
                            // a zero coefficient under a positive rhs counts as saturated
                            cand_valid_reg <= a_pos &&
                                              (func_reg == spp_pkg::FUNC_COL || b_zero);
                            if (func_reg == spp_pkg::FUNC_ROW) begin
                                cand_val_reg <= '1;
                            end
                        end
                        state_reg <= ST_UPD;
                    end
                end
                ST_DIV: begin
                    if (div_stat.done) begin
                        cand_val_reg   <= div_quo;
                        cand_valid_reg <= (div_quo != '0);
                        state_reg      <= ST_UPD;
                    end
                end
                ST_UPD: begin
                    if (better) begin
                        have_best_reg  <= 1'b1;
                        best_value_reg <= cand_val_reg;
                        best_index_reg <= pos_reg;
                    end
                    state_reg <= last_reg ? ST_EMIT : ST_IDLE;
                end
                ST_EMIT: begin
                    if (out_free) begin
                        out_kind_reg   <= func_reg;
                        out_found_reg  <= have_best_reg;
                        out_index_reg  <= have_best_reg ? best_index_reg : '0;
                        have_best_reg  <= 1'b0;
                        best_index_reg <= '0;
                        best_value_reg <= '0;
                        state_reg      <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tdata  = {{(spp_pkg::M_DATA_W - IW - 1){1'b0}}, out_index_reg, out_found_reg};

    a_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |-> state_reg == ST_DIV)
        else $error("divider finished outside the division state");

    a_no_index_without_pivot: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tdata[0]) |-> m_axis_tdata[IW:1] == '0)
        else $error("index reported without a pivot");

    a_best_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && out_free) |=> !have_best_reg && m_axis_tvalid)
        else $error("running best not cleared after a result");

    a_busy_after_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        in_beat |=> !s_axis_tready)
        else $error("ready while an element is still being processed");

    a_div_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

endmodule
